// ===== rtl/dws_pkg.sv =====
package dws_pkg;

    localparam int CMD_W        = 3;
    localparam int VAL_W        = 32;
    localparam int ST_W         = 2;
    localparam int POS_W        = 6;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_DUMP_FWD   = 3'd5,
        CMD_DUMP_BWD   = 3'd6
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the incoming word
        logic exec;      // decode and run the work that needs no walk
        logic walk;      // step through the stored entries
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_walk; // search or dump on a non-empty store
        logic walk_done; // final result of the walk is registered at the end of this cycle
    } t_dp_status;

endpackage

// ===== rtl/dws_ram.sv =====
module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dws_ctrl.sv =====
module dws_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dws_pkg::t_dp_status i_status,
    output dws_pkg::t_ctrl_cmd  o_cmd,
    output logic                o_busy
);
    import dws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE     = 3'b001,
        S_DISPATCH = 3'b010,
        S_WALK     = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        o_cmd.walk  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_walk ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/dws_datapath.sv =====
module dws_datapath #(
    parameter int CAPACITY = dws_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dws_pkg::t_ctrl_cmd                i_cmd,
    input  logic [dws_pkg::CMD_W-1:0]         i_command,
    input  logic signed [dws_pkg::VAL_W-1:0]  i_value,
    output dws_pkg::t_dp_status               o_status_dp,
    output logic                              o_valid,
    output logic [dws_pkg::ST_W-1:0]          o_status,
    output logic signed [dws_pkg::VAL_W-1:0]  o_item,
    output logic [dws_pkg::POS_W-1:0]         o_position,
    output logic                              o_last
);
    import dws_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_cmd                    r_cmd;
    logic [VAL_W-1:0]        r_value;
    logic [IDX_W-1:0]        r_front, n_front;
    logic [OCC_W-1:0]        r_count, n_count;
    logic [OCC_W-1:0]        r_issue, n_issue;
    logic                    r_rd_v,  n_rd_v;
    logic [OCC_W-1:0]        r_rd_i,  n_rd_i;

    logic                    r_valid, n_valid;
    t_status                 r_status, n_status;
    logic [VAL_W-1:0]        r_item,  n_item;
    logic [POS_W-1:0]        r_pos,   n_pos;
    logic                    r_last,  n_last;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [IDX_W-1:0]        ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    logic [IDX_W-1:0]        front_dec;
    logic [IDX_W-1:0]        front_inc;
    logic [OCC_W-1:0]        rd_off;
    logic [OCC_W-1:0]        pos_full;
    logic                    is_full;
    logic                    is_empty;
    logic                    rd_is_last;
    logic                    walk_done;

    // ring slot at offset off from base, one wrap at most
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign is_full    = (r_count == OCC_W'(CAPACITY));
    assign is_empty   = (r_count == '0);
    assign front_dec  = (r_front == '0) ? IDX_W'(CAPACITY - 1) : r_front - 1'b1;
    assign front_inc  = slot(r_front, IDX_W'(1));
    assign rd_off     = (r_cmd == CMD_DUMP_BWD) ? (r_count - 1'b1 - r_issue) : r_issue;
    assign ram_raddr  = slot(r_front, rd_off[IDX_W-1:0]);
    assign rd_is_last = (r_rd_i == r_count - 1'b1);
    assign pos_full   = r_rd_i + OCC_W'(1);

    assign o_status_dp.need_walk = !is_empty &&
        (r_cmd == CMD_SEARCH || r_cmd == CMD_DUMP_FWD || r_cmd == CMD_DUMP_BWD);
    assign o_status_dp.walk_done = walk_done;

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_issue   = r_issue;
        n_rd_v    = 1'b0;
        n_rd_i    = r_rd_i;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_item    = '0;
        n_pos     = '0;
        n_last    = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = (r_cmd == CMD_PUSH_FRONT) ? front_dec
                                              : slot(r_front, r_count[IDX_W-1:0]);
        walk_done = 1'b0;

        if (i_cmd.exec) begin
            n_issue = '0;
            unique case (r_cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    n_valid = 1'b1;
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_cmd == CMD_PUSH_FRONT) begin
                            n_front = front_dec;
                        end
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    n_valid = 1'b1;
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                        if (r_cmd == CMD_POP_FRONT) begin
                            n_front = front_inc;
                        end
                    end
                end
                CMD_SEARCH: begin
                    if (is_empty) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOTFOUND;
                    end
                end
                CMD_DUMP_FWD, CMD_DUMP_BWD: begin
                    if (is_empty) begin
                        n_valid  = 1'b1;
                        n_status = ST_EMPTY;
                    end
                end
                default: begin
                    // unused code: drop silently
                end
            endcase
        end

        if (i_cmd.walk) begin
            // issue the next read while checking the one in flight
            if (r_issue < r_count) begin
                n_issue = r_issue + 1'b1;
                n_rd_v  = 1'b1;
                n_rd_i  = r_issue;
            end
            if (r_rd_v) begin
                if (r_cmd == CMD_SEARCH) begin
                    if (ram_rdata == r_value) begin
                        n_valid   = 1'b1;
                        n_pos     = POS_W'(pos_full);
                        walk_done = 1'b1;
                    end else if (rd_is_last) begin
                        n_valid   = 1'b1;
                        n_status  = ST_NOTFOUND;
                        walk_done = 1'b1;
                    end
                end else begin
                    n_valid   = 1'b1;
                    n_item    = ram_rdata;
                    n_last    = rd_is_last;
                    walk_done = rd_is_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_issue <= '0;
            r_rd_v  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_issue <= n_issue;
            r_rd_v  <= n_rd_v;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= t_cmd'(i_command);
            r_value <= i_value;
        end
        r_rd_i   <= n_rd_i;
        r_status <= n_status;
        r_item   <= n_item;
        r_pos    <= n_pos;
        r_last   <= n_last;
    end

    dws_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_item     = r_item;
    assign o_position = r_pos;
    assign o_last     = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front < IDX_W'(CAPACITY - 1) || r_front == IDX_W'(CAPACITY - 1))
        else $error("front index outside the ring");

    a_dump_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |=> r_valid)
        else $error("dump words not back to back");

    a_pos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_pos != '0 |-> r_status == ST_OK && r_last && r_item == '0)
        else $error("search hit word malformed");

    a_walk_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |=> $stable(r_count) && $stable(r_front))
        else $error("store changed during a walk");

endmodule

// ===== rtl/deque_with_search.sv =====
// Bounded double-ended queue of signed 32-bit words in a ring store of
// CAPACITY entries, with search and dump. A command is taken when i_start is
// high and o_busy is low; results come back on o_valid for one cycle each and
// must be taken then, as the block cannot be held off. Push and pop give one
// status word, registered from the dispatch state, and the block is idle again
// after dispatch, ready for the next command. Search and dump step through the
// store one entry per cycle on the single read port of the entry RAM, whose
// read data is registered: a dump of n entries gives its n words on
// back-to-back cycles, and a search ends at the first hit at position p or
// after the last entry on a miss. An empty store answers a search or dump with
// one status word. Command code 7 gives no result.
module deque_with_search #(
    parameter int CAPACITY = dws_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [dws_pkg::CMD_W-1:0]         i_command,
    input  logic signed [dws_pkg::VAL_W-1:0]  i_value,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [dws_pkg::ST_W-1:0]          o_status,
    output logic signed [dws_pkg::VAL_W-1:0]  o_item,
    output logic [dws_pkg::POS_W-1:0]         o_position,
    output logic                              o_last
);
    import dws_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    dws_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd),
        .o_busy   (o_busy)
    );

    dws_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_status_dp (dp_status),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_item      (o_item),
        .o_position  (o_position),
        .o_last      (o_last)
    );

endmodule

// ===== test/deque_with_search_tb.sv =====
`timescale 1ns / 100ps

module deque_with_search_tb;
    import dws_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int MAX_REPORTS = 60;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        int                      idle_after;
        bit                      wait_drain;
    } cmd_word_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] item;
        logic [POS_W-1:0]        position;
        logic                    last;
    } deque_result_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic [CMD_W-1:0]        i_command;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_busy;
    logic                    o_valid;
    logic [ST_W-1:0]         o_status;
    logic signed [VAL_W-1:0] o_item;
    logic [POS_W-1:0]        o_position;
    logic                    o_last;

    cmd_word_t     cmd_backlog[$];
    deque_result_t pending_results[$];
    logic signed [VAL_W-1:0] pushed_values[$];
    bit            no_idle;
    int            error_count;

    // predictor state
    logic signed [VAL_W-1:0] model_slots [CAP];
    int model_head;
    int model_fill;

    // driver state
    cmd_word_t next_word;
    int        idle_left;

    deque_with_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_busy     (o_busy),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_item     (o_item),
        .o_position (o_position),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void predict_deque_results(logic [CMD_W-1:0] cmd,
                                                  logic signed [VAL_W-1:0] val);
        deque_result_t r;
        int off;
        bit hit;
        r = '{status: ST_OK, item: '0, position: '0, last: 1'b1};
        hit = 1'b0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (model_fill >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    if (cmd == CMD_PUSH_FRONT) begin
                        model_head = (model_head + CAP - 1) % CAP;
                        model_slots[model_head] = val;
                    end else begin
                        model_slots[(model_head + model_fill) % CAP] = val;
                    end
                    model_fill++;
                end
                pending_results.push_back(r);
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (cmd == CMD_POP_FRONT)
                        model_head = (model_head + 1) % CAP;
                    model_fill--;
                end
                pending_results.push_back(r);
            end
            CMD_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < model_fill; i++) begin
                    if (!hit && model_slots[(model_head + i) % CAP] == val) begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.position = POS_W'(i + 1);
                    end
                end
                pending_results.push_back(r);
            end
            CMD_DUMP_FWD, CMD_DUMP_BWD: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                    pending_results.push_back(r);
                end else begin
                    for (int i = 0; i < model_fill; i++) begin
                        off = (cmd == CMD_DUMP_FWD) ? i : model_fill - 1 - i;
                        r.item = model_slots[(model_head + off) % CAP];
                        r.last = (i == model_fill - 1);
                        pending_results.push_back(r);
                    end
                end
            end
            default: ;  // unused code: no word back, no state change
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            4, 5:    return $urandom_range(0, 7);  // small range, forces duplicates
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_key();
        if (pushed_values.size() != 0 && $urandom_range(0, 9) < 6)
            return pushed_values[$urandom_range(0, pushed_values.size() - 1)];
        return pick_value();
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                                      bit wait_drain = 1'b0);
        cmd_word_t w;
        w.cmd = cmd;
        w.value = val;
        w.wait_drain = wait_drain;
        w.idle_after = (no_idle || $urandom_range(0, 99) < 65) ? 0 : $urandom_range(1, 12);
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
            pushed_values.push_back(val);
            if (pushed_values.size() > 40)
                void'(pushed_values.pop_front());
        end
        cmd_backlog.push_back(w);
    endfunction

    function automatic void queue_random_cmd(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            queue_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        else if (roll < push_pct + pop_pct)
            queue_cmd($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom);
        else if (roll < 95)
            queue_cmd(CMD_SEARCH, pick_key());
        else if (roll < 99)
            queue_cmd($urandom_range(0, 1) ? CMD_DUMP_FWD : CMD_DUMP_BWD, $urandom);
        else
            queue_cmd(CMD_UNUSED, $urandom);
    endfunction

    // driver: sample acceptance, then present the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            idle_left = 0;
        end else begin
            if (i_start && !o_busy)
                predict_deque_results(i_command, i_value);
            if (i_start && o_busy) begin
                // hold the word until the block takes it
            end else if (idle_left > 0) begin
                idle_left--;
                i_start <= 1'b0;
            end else if (cmd_backlog.size() == 0) begin
                i_start <= 1'b0;
            end else if (cmd_backlog[0].wait_drain && pending_results.size() != 0) begin
                i_start <= 1'b0;
            end else begin
                next_word = cmd_backlog.pop_front();
                i_start   <= 1'b1;
                i_command <= next_word.cmd;
                i_value   <= next_word.value;
                idle_left = next_word.idle_after;
            end
        end
    end

    // monitor: every strobed word is taken and checked against the oldest prediction
    always @(posedge i_clk) begin
        deque_result_t got;
        deque_result_t want;
        if (i_rst_n && o_valid) begin
            got = '{status: o_status, item: o_item, position: o_position, last: o_last};
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected word: status=%0d item=%0d position=%0d last=%0d",
                             $time, got.status, got.item, got.position, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.item !== want.item ||
                    got.position !== want.position || got.last !== want.last) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected status=%0d item=%0d position=%0d last=%0d, actual status=%0d item=%0d position=%0d last=%0d",
                                 $time, want.status, want.item, want.position, want.last,
                                 got.status, got.item, got.position, got.last);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("deque_with_search verification failed");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_command   = '0;
        i_value     = '0;
        no_idle     = 1'b0;
        error_count = 0;
        model_head  = 0;
        model_fill  = 0;
        idle_left   = 0;
        foreach (model_slots[i]) model_slots[i] = '0;

        // empty store corners and the unused code
        queue_cmd(CMD_SEARCH, 5);
        queue_cmd(CMD_DUMP_FWD, 0);
        queue_cmd(CMD_DUMP_BWD, 0);
        queue_cmd(CMD_POP_FRONT, 0);
        queue_cmd(CMD_POP_BACK, 0);
        queue_cmd(CMD_UNUSED, -1);
        // extreme values, with a duplicate to check first-match order
        queue_cmd(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        queue_cmd(CMD_PUSH_BACK, 32'sh8000_0000);
        queue_cmd(CMD_PUSH_FRONT, 0);
        queue_cmd(CMD_PUSH_BACK, -1);
        queue_cmd(CMD_PUSH_FRONT, 0);
        queue_cmd(CMD_SEARCH, 0);
        queue_cmd(CMD_SEARCH, -1);
        queue_cmd(CMD_SEARCH, 32'sh8000_0000);
        queue_cmd(CMD_SEARCH, 12345);
        queue_cmd(CMD_DUMP_FWD, 0);
        queue_cmd(CMD_DUMP_BWD, 0);
        queue_cmd(CMD_POP_BACK, 0);
        queue_cmd(CMD_POP_FRONT, 0);
        queue_cmd(CMD_POP_BACK, 0);
        queue_cmd(CMD_POP_FRONT, 0);
        queue_cmd(CMD_POP_FRONT, 0);
        queue_cmd(CMD_POP_BACK, 0);
        queue_cmd(CMD_SEARCH, -1, 1'b1);

        // fill past capacity, each push on a random side, so the last pushes hit a full store
        for (int k = 0; k < CAP + 2; k++)
            queue_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        queue_cmd(CMD_SEARCH, pick_key());
        queue_cmd(CMD_DUMP_FWD, 0);
        queue_cmd(CMD_DUMP_BWD, 0);

        // drain, refill and mixed phases, waiting once for all outstanding results in between
        for (int k = 0; k < 44; k++) queue_random_cmd(15, 65);
        queue_cmd(CMD_SEARCH, pick_key(), 1'b1);
        for (int k = 0; k < 44; k++) queue_random_cmd(70, 10);
        for (int k = 0; k < 44; k++) queue_random_cmd(70, 10);
        for (int k = 0; k < 44; k++) queue_random_cmd(15, 65);
        for (int k = 0; k < 44; k++) queue_random_cmd(45, 35);
        no_idle = 1'b1;
        for (int k = 0; k < 40; k++) queue_random_cmd(45, 35);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_start || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (error_count == 0)
            $display("deque_with_search verification clean");
        else
            $display("deque_with_search verification failed");
        $finish;
    end

endmodule
